FILE: rtl/core/separable_box_filter_2d_assert.svh
// assertion macros for the box filter
`ifndef SEPARABLE_BOX_FILTER_2D_ASSERT_SVH
`define SEPARABLE_BOX_FILTER_2D_ASSERT_SVH

// same-cycle implication, gated by reset
`define SBF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, gated by reset
`define SBF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/core/sbf_pkg.sv
package sbf_pkg;

  localparam int MAX_KERNEL  = 15;
  localparam int MAX_WIDTH   = 1024;
  localparam int PIXEL_BITS  = 8;

  localparam int K_W         = 4;
  localparam int W_W         = 11;
  localparam int H_W         = 16;
  localparam int COL_W       = $clog2(MAX_WIDTH);
  localparam int SLOT_W      = $clog2(MAX_KERNEL);
  localparam int HALF_W      = $clog2(MAX_KERNEL / 2 + 1);
  localparam int ADDR_W      = SLOT_W + COL_W;
  localparam int STORE_DEPTH = MAX_KERNEL * MAX_WIDTH;
  localparam int ACC_W       = $clog2(MAX_KERNEL * ((1 << PIXEL_BITS) - 1) + 1);
  localparam int DCNT_W      = $clog2(ACC_W + 1);
  localparam int CAP         = MAX_KERNEL / 2 + 1;
  localparam int CAP_W       = $clog2(CAP);
  localparam int TAP_W       = $clog2(MAX_KERNEL + 1);

  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;

  localparam logic [CFG_IDX_W-1:0] REG_KERNEL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd2;

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  typedef struct packed {
    logic clr;
    logic add;
    logic start;
  } alu_ctrl_t;

  typedef struct packed {
    logic                  busy;
    logic [PIXEL_BITS-1:0] quot;
  } alu_stat_t;

endpackage

FILE: rtl/core/sbf_if.sv
interface sbf_in_if import sbf_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic                  opcode;
  logic [PIXEL_BITS-1:0] pixel_in;
  modport source (output valid, opcode, pixel_in, input ready);
  modport sink   (input valid, opcode, pixel_in, output ready);
endinterface

interface sbf_out_if import sbf_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [PIXEL_BITS-1:0] pixel_out;
  logic                  last;
  logic                  frame_end;
  logic                  config_error;
  modport source (output valid, pixel_out, last, frame_end, config_error, input ready);
  modport sink   (input valid, pixel_out, last, frame_end, config_error, output ready);
endinterface

interface sbf_cfg_if import sbf_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/core/sbf_ram.sv
module sbf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/core/sbf_alu.sv
module sbf_alu import sbf_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  alu_ctrl_t             ctrl,
  input  logic [PIXEL_BITS-1:0] operand,
  input  logic [K_W-1:0]        divisor,
  output alu_stat_t             stat
);

  logic [ACC_W-1:0]  acc_r;
  logic [K_W-1:0]    rem_r;
  logic [DCNT_W-1:0] cnt_r;
  logic [K_W:0]      trial;
  logic              fits;

  // restoring division, one quotient bit a cycle, quotient shifts into acc
  assign trial = {rem_r, acc_r[ACC_W-1]};
  assign fits  = trial >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (ctrl.start) begin
      cnt_r <= DCNT_W'(ACC_W);
    end else if (cnt_r != '0) begin
      cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.clr) begin
      acc_r <= '0;
    end else if (ctrl.add) begin
      acc_r <= acc_r + ACC_W'(operand);
    end else if (ctrl.start) begin
      rem_r <= '0;
    end else if (cnt_r != '0) begin
      rem_r <= fits ? K_W'(trial - {1'b0, divisor}) : trial[K_W-1:0];
      acc_r <= {acc_r[ACC_W-2:0], fits};
    end
  end

  assign stat.busy = cnt_r != '0;
  assign stat.quot = acc_r[PIXEL_BITS-1:0];

endmodule

FILE: rtl/core/separable_box_filter_2d.sv
// channel  | dir | payload                                      | accepted when
// in_if    | in  | opcode, pixel_in                             | valid && ready
// out_if   | out | pixel_out, last, frame_end, config_error     | valid && ready
// cfg_if   | in  | index, data (0 kernel, 1 width, 2 height)    | valid && ready
//
// one shared accumulate/divide unit does every tap sum and every division by k
// pixel: accept, then per horizontal average (set, taps, start, divide), then advance and output check
// each output: set, a read and an add per vertical tap, start, divide, done, emit; 8 per request at most
// reset is synchronous; positions clear, registers return to k=3, 512 x 512
// in_if.ready is high only in idle with no register write offered; a stalled output holds emit
// cfg_if.ready is high only in idle; a write to register 0, 1 or 2 restarts the frame position

`include "separable_box_filter_2d_assert.svh"

module separable_box_filter_2d import sbf_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  sbf_in_if.sink       in_if,
  sbf_out_if.source    out_if,
  sbf_cfg_if.sink      cfg_if
);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_HSET  = 4'd1;
  localparam logic [3:0] ST_HACC  = 4'd2;
  localparam logic [3:0] ST_HDIV  = 4'd3;
  localparam logic [3:0] ST_HWAIT = 4'd4;
  localparam logic [3:0] ST_ADV   = 4'd5;
  localparam logic [3:0] ST_OCHK  = 4'd6;
  localparam logic [3:0] ST_VSET  = 4'd7;
  localparam logic [3:0] ST_VRD   = 4'd8;
  localparam logic [3:0] ST_VADD  = 4'd9;
  localparam logic [3:0] ST_VDIV  = 4'd10;
  localparam logic [3:0] ST_VWAIT = 4'd11;
  localparam logic [3:0] ST_EMIT  = 4'd12;
  localparam logic [3:0] ST_ERR   = 4'd13;

  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(MAX_KERNEL - 1);

  // configuration
  logic [K_W-1:0] kernel_r;
  logic [W_W-1:0] width_r;
  logic [H_W-1:0] height_r;

  // positions and their slot (mod kernel store) shadows
  logic [H_W-1:0]    in_row_r, out_row_r;
  logic [COL_W-1:0]  in_col_r, out_col_r;
  logic [SLOT_W-1:0] wcol_r, irow_slot_r, orow_slot_r;

  logic [3:0]            state_r;
  logic [PIXEL_BITS-1:0] window_r [MAX_KERNEL];
  logic [COL_W-1:0]      hx_r, hx_end_r;
  logic [TAP_W-1:0]      taps_r;
  logic [SLOT_W-1:0]     slot_r;
  logic [CAP_W-1:0]      nres_r;

  // output register
  logic                  out_valid_r;
  logic [PIXEL_BITS-1:0] out_pix_r;
  logic                  out_last_r, out_fe_r, out_err_r;

  logic [HALF_W-1:0]     half;
  logic [COL_W-1:0]      wm1;
  logic [H_W-1:0]        hm1;
  logic                  cfg_bad;
  logic                  in_acc, cfg_acc, out_free, emit_go;
  logic                  at_row_end;
  logic                  cur_ready, nxt_ready, is_fe, emit_last;
  logic [COL_W-1:0]      nxt_col;
  logic [H_W-1:0]        nxt_row;
  logic [TAP_W-1:0]      htaps, vtaps;
  logic [SLOT_W-1:0]     vslot0;
  logic [H_W:0]          vlo, vhi, rb;
  logic [HALF_W-1:0]     vback;

  alu_ctrl_t             alu_ctrl;
  alu_stat_t             alu_stat;
  logic [PIXEL_BITS-1:0] alu_opnd;
  logic                  ram_we;
  logic [ADDR_W-1:0]     ram_waddr, ram_raddr;
  logic [PIXEL_BITS-1:0] ram_rdata;

  assign half = HALF_W'(kernel_r >> 1);
  assign wm1  = COL_W'(width_r - 1'b1);
  assign hm1  = height_r - 1'b1;

  // even kernel, empty or oversize frame, kernel wider or taller than frame
  assign cfg_bad = !kernel_r[0] || (width_r == '0) || (width_r > W_W'(MAX_WIDTH)) ||
                   (height_r == '0) || (W_W'(kernel_r) > width_r) ||
                   (H_W'(kernel_r) > height_r);

  assign in_acc   = in_if.valid && in_if.ready;
  assign cfg_acc  = cfg_if.valid && cfg_if.ready;
  assign out_free = !out_valid_r || out_if.ready;
  assign emit_go  = ((state_r == ST_EMIT) || (state_r == ST_ERR)) && out_free;

  // a register write takes the idle slot ahead of a request
  assign in_if.ready  = (state_r == ST_IDLE) && !cfg_if.valid;
  assign cfg_if.ready = state_r == ST_IDLE;

  assign at_row_end = in_col_r == wm1;

  // output (r, c) may go once the horizontal average at (r + half, c) exists
  function automatic logic pos_ready(input logic [H_W-1:0] r, input logic [COL_W-1:0] c,
                                     input logic [HALF_W-1:0] hb,
                                     input logic [W_W-1:0] w, input logic [H_W-1:0] h,
                                     input logic [H_W-1:0] irow,
                                     input logic [COL_W-1:0] icol);
    logic [H_W:0] rr;
    logic [W_W-1:0] m;
    rr = {1'b0, r} + (H_W+1)'(hb);
    m = W_W'(c) + W_W'(hb);
    if (m > w - 1'b1) begin
      m = w - 1'b1;
    end
    if (rr >= {1'b0, h}) begin
      pos_ready = irow == h;
    end else if (rr < {1'b0, irow}) begin
      pos_ready = 1'b1;
    end else if (rr == {1'b0, irow}) begin
      pos_ready = (m + 1'b1) <= W_W'(icol);
    end else begin
      pos_ready = 1'b0;
    end
  endfunction

  assign nxt_col   = (out_col_r == wm1) ? '0 : out_col_r + 1'b1;
  assign nxt_row   = (out_col_r == wm1) ? out_row_r + 1'b1 : out_row_r;
  assign is_fe     = (out_row_r == hm1) && (out_col_r == wm1);
  assign cur_ready = pos_ready(out_row_r, out_col_r, half, width_r, height_r,
                               in_row_r, in_col_r);
  assign nxt_ready = pos_ready(nxt_row, nxt_col, half, width_r, height_r,
                               in_row_r, in_col_r);
  assign emit_last = is_fe || (nres_r == CAP_W'(CAP - 1)) || !nxt_ready;

  // horizontal taps run from the newest pixel back to max(hx - half, 0)
  assign htaps = (hx_r >= COL_W'(half)) ?
                 TAP_W'(in_col_r - hx_r + COL_W'(half) + 1'b1) :
                 TAP_W'(in_col_r + 1'b1);

  // vertical taps run from max(r - half, 0) up to min(r + half, h - 1)
  assign rb     = {1'b0, out_row_r} + (H_W+1)'(half);
  assign vlo    = (out_row_r >= H_W'(half)) ? {1'b0, out_row_r - H_W'(half)} : '0;
  assign vhi    = (rb > {1'b0, hm1}) ? {1'b0, hm1} : rb;
  assign vtaps  = TAP_W'(vhi - vlo + 1'b1);
  assign vback  = (out_row_r >= H_W'(half)) ? half : HALF_W'(out_row_r);
  assign vslot0 = (orow_slot_r >= SLOT_W'(vback)) ? orow_slot_r - SLOT_W'(vback) :
                  SLOT_W'(orow_slot_r + SLOT_W'(MAX_KERNEL) - SLOT_W'(vback));

  // shared unit control
  always_comb begin
    alu_ctrl = '0;
    alu_opnd = window_r[slot_r];
    unique case (state_r)
      ST_HSET, ST_VSET: alu_ctrl.clr   = 1'b1;
      ST_HACC:          alu_ctrl.add   = 1'b1;
      ST_VADD: begin
        alu_ctrl.add = 1'b1;
        alu_opnd     = ram_rdata;
      end
      ST_HDIV, ST_VDIV: alu_ctrl.start = 1'b1;
      default: ;
    endcase
  end

  assign ram_we    = (state_r == ST_HWAIT) && !alu_stat.busy;
  assign ram_waddr = {irow_slot_r, hx_r};
  assign ram_raddr = {slot_r, out_col_r};

  sbf_alu u_alu (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctrl    (alu_ctrl),
    .operand (alu_opnd),
    .divisor (kernel_r),
    .stat    (alu_stat)
  );

  sbf_ram #(
    .WIDTH (PIXEL_BITS),
    .DEPTH (STORE_DEPTH)
  ) u_line_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (alu_stat.quot),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // row window of recent pixels
  always_ff @(posedge clk) begin
    if (in_acc && !cfg_bad && (in_if.opcode == OP_PIXEL) && (in_row_r < height_r)) begin
      window_r[wcol_r] <= in_if.pixel_in;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      kernel_r    <= K_W'(3);
      width_r     <= W_W'(512);
      height_r    <= H_W'(512);
      in_row_r    <= '0;
      in_col_r    <= '0;
      out_row_r   <= '0;
      out_col_r   <= '0;
      wcol_r      <= '0;
      irow_slot_r <= '0;
      orow_slot_r <= '0;
      out_valid_r <= 1'b0;
      nres_r      <= '0;
    end else begin
      if (emit_go) begin
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            if (cfg_bad) begin
              state_r <= ST_ERR;
            end else if ((in_if.opcode == OP_PIXEL) && (in_row_r < height_r)) begin
              hx_r     <= in_col_r - COL_W'(half);
              hx_end_r <= at_row_end ? wm1 : in_col_r - COL_W'(half);
              state_r  <= (in_col_r >= COL_W'(half)) ? ST_HSET : ST_ADV;
            end else begin
              // flush, or a pixel past the end of the frame
              state_r <= ST_OCHK;
            end
          end
        end
        ST_HSET: begin
          taps_r  <= htaps;
          slot_r  <= wcol_r;
          state_r <= ST_HACC;
        end
        ST_HACC: begin
          slot_r <= (slot_r == '0) ? SLOT_LAST : slot_r - 1'b1;
          taps_r <= taps_r - 1'b1;
          if (taps_r == TAP_W'(1)) begin
            state_r <= ST_HDIV;
          end
        end
        ST_HDIV: state_r <= ST_HWAIT;
        ST_HWAIT: begin
          if (!alu_stat.busy) begin
            if (hx_r == hx_end_r) begin
              state_r <= ST_ADV;
            end else begin
              hx_r    <= hx_r + 1'b1;
              state_r <= ST_HSET;
            end
          end
        end
        ST_ADV: begin
          if (at_row_end) begin
            in_col_r    <= '0;
            wcol_r      <= '0;
            in_row_r    <= in_row_r + 1'b1;
            irow_slot_r <= (irow_slot_r == SLOT_LAST) ? '0 : irow_slot_r + 1'b1;
          end else begin
            in_col_r <= in_col_r + 1'b1;
            wcol_r   <= (wcol_r == SLOT_LAST) ? '0 : wcol_r + 1'b1;
          end
          state_r <= ST_OCHK;
        end
        ST_OCHK: begin
          nres_r  <= '0;
          state_r <= cur_ready ? ST_VSET : ST_IDLE;
        end
        ST_VSET: begin
          taps_r  <= vtaps;
          slot_r  <= vslot0;
          state_r <= ST_VRD;
        end
        ST_VRD: state_r <= ST_VADD;
        ST_VADD: begin
          slot_r <= (slot_r == SLOT_LAST) ? '0 : slot_r + 1'b1;
          taps_r <= taps_r - 1'b1;
          state_r <= (taps_r == TAP_W'(1)) ? ST_VDIV : ST_VRD;
        end
        ST_VDIV: state_r <= ST_VWAIT;
        ST_VWAIT: begin
          if (!alu_stat.busy) begin
            state_r <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            out_pix_r   <= alu_stat.quot;
            out_last_r  <= emit_last;
            out_fe_r    <= is_fe;
            out_err_r   <= 1'b0;
            nres_r      <= nres_r + 1'b1;
            if (is_fe) begin
              // frame done: every position restarts
              in_row_r    <= '0;
              in_col_r    <= '0;
              out_row_r   <= '0;
              out_col_r   <= '0;
              wcol_r      <= '0;
              irow_slot_r <= '0;
              orow_slot_r <= '0;
            end else begin
              out_col_r <= nxt_col;
              out_row_r <= nxt_row;
              if (out_col_r == wm1) begin
                orow_slot_r <= (orow_slot_r == SLOT_LAST) ? '0 : orow_slot_r + 1'b1;
              end
            end
            state_r <= emit_last ? ST_IDLE : ST_VSET;
          end
        end
        ST_ERR: begin
          if (out_free) begin
            out_pix_r   <= '0;
            out_last_r  <= 1'b1;
            out_fe_r    <= 1'b0;
            out_err_r   <= 1'b1;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase

      // register writes restart the frame
      if (cfg_acc) begin
        priority if (cfg_if.index == REG_KERNEL) begin
          kernel_r <= cfg_if.data[K_W-1:0];
        end else if (cfg_if.index == REG_WIDTH) begin
          width_r <= cfg_if.data[W_W-1:0];
        end else if (cfg_if.index == REG_HEIGHT) begin
          height_r <= cfg_if.data[H_W-1:0];
        end else begin
        end
        if ((cfg_if.index == REG_KERNEL) || (cfg_if.index == REG_WIDTH) ||
            (cfg_if.index == REG_HEIGHT)) begin
          in_row_r    <= '0;
          in_col_r    <= '0;
          out_row_r   <= '0;
          out_col_r   <= '0;
          wcol_r      <= '0;
          irow_slot_r <= '0;
          orow_slot_r <= '0;
        end
      end
    end
  end

  assign out_if.valid        = out_valid_r;
  assign out_if.pixel_out    = out_pix_r;
  assign out_if.last         = out_last_r;
  assign out_if.frame_end    = out_fe_r;
  assign out_if.config_error = out_err_r;

  // error results are a lone zero pixel
  `SBF_ASSERT_NOW(a_err_shape, out_valid_r && out_err_r, (out_pix_r == '0) && out_last_r && !out_fe_r, "error result malformed")
  // the frame's final pixel always closes its request
  `SBF_ASSERT_NOW(a_fe_last, out_valid_r && out_fe_r, out_last_r, "frame end without last")
  // a non-final output goes straight on to the next vertical sum
  `SBF_ASSERT_NEXT(a_emit_cont, (state_r == ST_EMIT) && out_free && !emit_last && !cfg_acc, state_r == ST_VSET, "sequencer left output run early")

endmodule
